@@ hw/rtl/cau_pkg.sv @@
// ----------------------------------------------------------------------------
// cau_pkg
// Types, codes and rounding helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

    localparam logic [2:0] KIND_ADD  = 3'd0;
    localparam logic [2:0] KIND_SUB  = 3'd1;
    localparam logic [2:0] KIND_MUL  = 3'd2;
    localparam logic [2:0] KIND_DIV  = 3'd3;
    localparam logic [2:0] KIND_POW  = 3'd4;
    localparam logic [2:0] KIND_COPY = 3'd5;

    localparam logic signed [31:0] Q_ONE = 32'sh0001_0000;

    // Quotient bits produced per lane: 32 integer bits plus 16 fraction bits
    // plus one extra bit used for rounding.
    localparam int QBITS = 49;
    localparam int FRAC_EXTRA = 17;

    typedef enum logic [2:0] {
        ACC_NONE,
        ACC_RE_ADD,
        ACC_RE_SUB,
        ACC_IM_ADD,
        ACC_IM_SUB,
        ACC_DEN_ADD
    } acc_t;

    typedef struct packed {
        logic clear;
        logic issue;
        acc_t tgt;
    } mac_ctl_t;

    typedef struct packed {
        logic              sat;
        logic signed [31:0] val;
    } sat_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ALU,
        ST_MAC,
        ST_MRND,
        ST_DCHK,
        ST_DWAIT,
        ST_DRND,
        ST_PLOOP,
        ST_DONE
    } st_t;

    // Clip a sign/magnitude value to the signed 32-bit range.
    function automatic sat_t sat_sm(input logic neg, input logic [48:0] mag);
        sat_t r;
        r.sat = 1'b0;
        if (neg)
        begin
            if (mag > 49'h0_8000_0000)
            begin
                r.sat = 1'b1;
                r.val = 32'sh8000_0000;
            end
            else
            begin
                r.val = -$signed(mag[31:0]);
            end
        end
        else
        begin
            if (mag > 49'h0_7FFF_FFFF)
            begin
                r.sat = 1'b1;
                r.val = 32'sh7FFF_FFFF;
            end
            else
            begin
                r.val = $signed(mag[31:0]);
            end
        end
        return r;
    endfunction

    function automatic sat_t clip33(input logic signed [32:0] s);
        sat_t r;
        r.sat = 1'b0;
        r.val = s[31:0];
        if (s > 33'sh0_7FFF_FFFF)
        begin
            r.sat = 1'b1;
            r.val = 32'sh7FFF_FFFF;
        end
        else if (s < -33'sh0_8000_0000)
        begin
            r.sat = 1'b1;
            r.val = 32'sh8000_0000;
        end
        return r;
    endfunction

    // Round a Q32.32 product sum to Q16.16, ties away from zero.
    function automatic sat_t rnd_mul(input logic signed [64:0] acc);
        logic        neg;
        logic [64:0] mag;
        logic [63:0] t;
        neg = acc[64];
        mag = neg ? 65'(-acc) : 65'(acc);
        t   = mag[63:0] + 64'd32768;
        return sat_sm(neg, {1'b0, t[63:16]});
    endfunction

    // Round a quotient carrying one extra fraction bit; overflow saturates.
    function automatic sat_t rnd_div(input logic neg, input logic ovf,
                                     input logic [QBITS-1:0] q);
        logic [QBITS:0] t;
        t = {1'b0, q} + {{QBITS{1'b0}}, 1'b1};
        if (ovf)
        begin
            return sat_sm(neg, 49'h1_0000_0000_0000);
        end
        return sat_sm(neg, t[QBITS:1]);
    endfunction

endpackage

@@ hw/rtl/cau_channels_if.sv @@
// ----------------------------------------------------------------------------
// cau channel interfaces
// Valid/ready channels for operand beats and result beats.
// ----------------------------------------------------------------------------
interface cau_req_if;
    logic               valid;
    logic               ready;
    logic [2:0]         kind;
    logic signed [31:0] x_re;
    logic signed [31:0] x_im;
    logic signed [31:0] y_re;
    logic signed [31:0] y_im;
    logic signed [4:0]  exponent;

    modport source (output valid, kind, x_re, x_im, y_re, y_im, exponent, input ready);
    modport sink (input valid, kind, x_re, x_im, y_re, y_im, exponent, output ready);
endinterface

interface cau_rsp_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] res_re;
    logic signed [31:0] res_im;
    logic               div_zero;
    logic               saturated;

    modport source (output valid, res_re, res_im, div_zero, saturated, input ready);
    modport sink (input valid, res_re, res_im, div_zero, saturated, output ready);
endinterface

@@ hw/rtl/cau_mac.sv @@
// ----------------------------------------------------------------------------
// cau_mac
// Shared 32x32 multiplier with registered product and three accumulators.
// ----------------------------------------------------------------------------
module cau_mac
(
    input  logic               clk,
    input  logic               rst_n,
    input  cau_pkg::mac_ctl_t  ctl,
    input  logic signed [31:0] op_a,
    input  logic signed [31:0] op_b,
    output logic signed [64:0] acc_re,
    output logic signed [64:0] acc_im,
    output logic [63:0]        acc_den
);

    logic signed [63:0] prod_reg;
    cau_pkg::acc_t      tgt_reg;
    logic signed [64:0] acc_re_reg;
    logic signed [64:0] acc_re_next;
    logic signed [64:0] acc_im_reg;
    logic signed [64:0] acc_im_next;
    logic [63:0]        acc_den_reg;
    logic [63:0]        acc_den_next;
    logic signed [64:0] prod_ext;

    assign prod_ext = {prod_reg[63], prod_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tgt_reg <= cau_pkg::ACC_NONE;
        end
        else
        begin
            tgt_reg <= ctl.issue ? ctl.tgt : cau_pkg::ACC_NONE;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.issue)
        begin
            prod_reg <= op_a * op_b;
        end
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
        acc_den_reg <= acc_den_next;
    end

    always_comb
    begin
        acc_re_next  = acc_re_reg;
        acc_im_next  = acc_im_reg;
        acc_den_next = acc_den_reg;
        case (tgt_reg)
            cau_pkg::ACC_RE_ADD:  acc_re_next  = acc_re_reg + prod_ext;
            cau_pkg::ACC_RE_SUB:  acc_re_next  = acc_re_reg - prod_ext;
            cau_pkg::ACC_IM_ADD:  acc_im_next  = acc_im_reg + prod_ext;
            cau_pkg::ACC_IM_SUB:  acc_im_next  = acc_im_reg - prod_ext;
            cau_pkg::ACC_DEN_ADD: acc_den_next = acc_den_reg + prod_reg;
            default:              acc_re_next  = acc_re_reg;
        endcase
        if (ctl.clear)
        begin
            acc_re_next  = '0;
            acc_im_next  = '0;
            acc_den_next = '0;
        end
    end

    assign acc_re  = acc_re_reg;
    assign acc_im  = acc_im_reg;
    assign acc_den = acc_den_reg;

    // a clear must never drop a product still in flight
    a_clear_idle: assert property (@(posedge clk) disable iff (!rst_n)
        ctl.clear |-> tgt_reg == cau_pkg::ACC_NONE)
        else $error("accumulator cleared with product pending");

endmodule

@@ hw/rtl/cau_div.sv @@
// ----------------------------------------------------------------------------
// cau_div
// Two-lane restoring divider, one quotient bit per lane each cycle.
// ----------------------------------------------------------------------------
module cau_div
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [63:0]                num_re,
    input  logic [63:0]                num_im,
    input  logic [63:0]                den,
    output logic                       done,
    output logic [cau_pkg::QBITS-1:0]  q_re,
    output logic [cau_pkg::QBITS-1:0]  q_im,
    output logic                       ovf_re,
    output logic                       ovf_im
);

    localparam int CW = $clog2(cau_pkg::QBITS + 1);

    logic [63:0]               den_reg;
    logic [63:0]               rem_reg  [2];
    logic [cau_pkg::QBITS-1:0] bits_reg [2];
    logic [cau_pkg::QBITS-1:0] q_reg    [2];
    logic                      ovf_reg  [2];
    logic [CW-1:0]             cnt_reg;
    logic                      run_reg;
    logic                      done_reg;
    logic [63:0]               num      [2];
    logic [64:0]               trial    [2];

    assign num[0] = num_re;
    assign num[1] = num_im;

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            trial[l] = {rem_reg[l], bits_reg[l][cau_pkg::QBITS-1]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                run_reg <= 1'b1;
                cnt_reg <= CW'(cau_pkg::QBITS);
            end
            else if (run_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1))
                begin
                    run_reg  <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            den_reg <= den;
            for (int l = 0; l < 2; l++)
            begin
                rem_reg[l]  <= {32'b0, num[l][63:32]};
                bits_reg[l] <= {num[l][31:0], {cau_pkg::FRAC_EXTRA{1'b0}}};
                q_reg[l]    <= '0;
                ovf_reg[l]  <= {32'b0, num[l]} >= {den, 32'b0};
            end
        end
        else if (run_reg)
        begin
            for (int l = 0; l < 2; l++)
            begin
                bits_reg[l] <= bits_reg[l] << 1;
                if (trial[l] >= {1'b0, den_reg})
                begin
                    rem_reg[l] <= 64'(trial[l] - {1'b0, den_reg});
                    q_reg[l]   <= {q_reg[l][cau_pkg::QBITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[l] <= trial[l][63:0];
                    q_reg[l]   <= {q_reg[l][cau_pkg::QBITS-2:0], 1'b0};
                end
            end
        end
    end

    assign done   = done_reg;
    assign q_re   = q_reg[0];
    assign q_im   = q_reg[1];
    assign ovf_re = ovf_reg[0];
    assign ovf_im = ovf_reg[1];

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !run_reg)
        else $error("divider restarted while running");

endmodule

@@ hw/rtl/complex_arithmetic_unit.sv @@
// Sequencing: add, subtract, copy and unknown kinds pass through the ALU state;
// multiply runs four products; divide runs six products, then 49 divider steps.
// Power: one multiply pass per factor, plus a divide when the exponent is negative.
// One item at a time: a request is accepted only while the sequencer is idle.
// The next item is accepted while a result waits in the output register.
// Reset (rst_n, asynchronous, active low) clears the sequencer and output valid.
// ----------------------------------------------------------------------------
// complex_arithmetic_unit
// Q16.16 complex add, subtract, multiply, divide, integer power and copy,
// sequenced over one shared multiplier and a two-lane iterative divider.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit
#(
    parameter int MAX_EXPONENT = 15
)
(
    input  logic       clk,
    input  logic       rst_n,
    cau_req_if.sink    req,
    cau_rsp_if.source  rsp
);

    localparam int EXP_BITS = $clog2(MAX_EXPONENT + 1);
    localparam int NW = (EXP_BITS > 5 ? EXP_BITS : 5) + 1;

    cau_pkg::st_t       st_reg;
    cau_pkg::st_t       st_next;
    logic [2:0]         kind_reg;
    logic signed [31:0] a_re_reg;
    logic signed [31:0] a_im_reg;
    logic signed [31:0] b_re_reg;
    logic signed [31:0] b_im_reg;
    logic [NW-2:0]      cnt_reg;
    logic               div_mode_reg;
    logic [2:0]         step_reg;
    logic               sat_reg;
    logic               dz_reg;
    logic               nre_neg_reg;
    logic               nim_neg_reg;
    logic               out_valid_reg;
    logic signed [31:0] out_re_reg;
    logic signed [31:0] out_im_reg;
    logic               out_dz_reg;
    logic               out_sat_reg;

    logic               accept;
    logic               load_out;
    logic [2:0]         last_step;
    logic signed [NW-1:0] exp_ext;
    logic signed [NW-1:0] exp_clamp;
    logic signed [NW-1:0] max_exp;

    cau_pkg::mac_ctl_t  mac_ctl;
    logic signed [31:0] op_a;
    logic signed [31:0] op_b;
    logic signed [64:0] acc_re;
    logic signed [64:0] acc_im;
    logic [63:0]        acc_den;

    logic               div_start;
    logic               div_done;
    logic [64:0]        mag_re;
    logic [64:0]        mag_im;
    logic [cau_pkg::QBITS-1:0] q_re;
    logic [cau_pkg::QBITS-1:0] q_im;
    logic               ovf_re;
    logic               ovf_im;

    cau_pkg::sat_t      alu_re;
    cau_pkg::sat_t      alu_im;
    cau_pkg::sat_t      mr_re;
    cau_pkg::sat_t      mr_im;
    cau_pkg::sat_t      dr_re;
    cau_pkg::sat_t      dr_im;

    assign accept   = req.valid && req.ready;
    assign load_out = (st_reg == cau_pkg::ST_DONE) && (!out_valid_reg || rsp.ready);
    assign last_step = div_mode_reg ? 3'd6 : 3'd4;

    assign max_exp  = NW'(MAX_EXPONENT);
    assign exp_ext  = NW'(req.exponent);
    assign exp_clamp = (exp_ext > max_exp) ? max_exp :
                       (exp_ext < -max_exp) ? -max_exp : exp_ext;

    assign mag_re = acc_re[64] ? 65'(-acc_re) : 65'(acc_re);
    assign mag_im = acc_im[64] ? 65'(-acc_im) : 65'(acc_im);

    always_comb
    begin
        case (kind_reg)
            cau_pkg::KIND_SUB:
            begin
                alu_re = cau_pkg::clip33(33'(a_re_reg) - 33'(b_re_reg));
                alu_im = cau_pkg::clip33(33'(a_im_reg) - 33'(b_im_reg));
            end
            default:
            begin
                alu_re = cau_pkg::clip33(33'(a_re_reg) + 33'(b_re_reg));
                alu_im = cau_pkg::clip33(33'(a_im_reg) + 33'(b_im_reg));
            end
        endcase
    end

    assign mr_re = cau_pkg::rnd_mul(acc_re);
    assign mr_im = cau_pkg::rnd_mul(acc_im);
    assign dr_re = cau_pkg::rnd_div(nre_neg_reg, ovf_re, q_re);
    assign dr_im = cau_pkg::rnd_div(nim_neg_reg, ovf_im, q_im);

    // next state
    always_comb
    begin
        st_next = st_reg;
        case (st_reg)
            cau_pkg::ST_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        cau_pkg::KIND_MUL: st_next = cau_pkg::ST_MAC;
                        cau_pkg::KIND_DIV: st_next = cau_pkg::ST_MAC;
                        cau_pkg::KIND_POW:
                            st_next = (exp_clamp < 0) ? cau_pkg::ST_MAC : cau_pkg::ST_PLOOP;
                        default:           st_next = cau_pkg::ST_ALU;
                    endcase
                end
            end
            cau_pkg::ST_ALU:   st_next = cau_pkg::ST_DONE;
            cau_pkg::ST_MAC:
            begin
                if (step_reg == last_step)
                begin
                    st_next = div_mode_reg ? cau_pkg::ST_DCHK : cau_pkg::ST_MRND;
                end
            end
            cau_pkg::ST_MRND:
                st_next = (kind_reg == cau_pkg::KIND_POW) ? cau_pkg::ST_PLOOP : cau_pkg::ST_DONE;
            cau_pkg::ST_DCHK:
                st_next = (acc_den == 64'd0) ? cau_pkg::ST_DONE : cau_pkg::ST_DWAIT;
            cau_pkg::ST_DWAIT:
            begin
                if (div_done)
                begin
                    st_next = cau_pkg::ST_DRND;
                end
            end
            cau_pkg::ST_DRND:
                st_next = (kind_reg == cau_pkg::KIND_POW) ? cau_pkg::ST_PLOOP : cau_pkg::ST_DONE;
            cau_pkg::ST_PLOOP:
                st_next = (cnt_reg == '0) ? cau_pkg::ST_DONE : cau_pkg::ST_MAC;
            cau_pkg::ST_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    st_next = cau_pkg::ST_IDLE;
                end
            end
            default: st_next = cau_pkg::ST_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        req.ready     = (st_reg == cau_pkg::ST_IDLE);
        div_start     = (st_reg == cau_pkg::ST_DCHK) && (acc_den != 64'd0);
        mac_ctl.clear = (st_reg == cau_pkg::ST_MAC) && (step_reg == 3'd0);
        mac_ctl.issue = (st_reg == cau_pkg::ST_MAC) && (step_reg < last_step);
        mac_ctl.tgt   = cau_pkg::ACC_NONE;
        op_a          = a_re_reg;
        op_b          = b_re_reg;
        case ({div_mode_reg, step_reg})
            4'b0_000: begin op_a = a_re_reg; op_b = b_re_reg; mac_ctl.tgt = cau_pkg::ACC_RE_ADD; end
            4'b0_001: begin op_a = a_im_reg; op_b = b_im_reg; mac_ctl.tgt = cau_pkg::ACC_RE_SUB; end
            4'b0_010: begin op_a = a_re_reg; op_b = b_im_reg; mac_ctl.tgt = cau_pkg::ACC_IM_ADD; end
            4'b0_011: begin op_a = a_im_reg; op_b = b_re_reg; mac_ctl.tgt = cau_pkg::ACC_IM_ADD; end
            4'b1_000: begin op_a = b_re_reg; op_b = b_re_reg; mac_ctl.tgt = cau_pkg::ACC_DEN_ADD; end
            4'b1_001: begin op_a = b_im_reg; op_b = b_im_reg; mac_ctl.tgt = cau_pkg::ACC_DEN_ADD; end
            4'b1_010: begin op_a = a_re_reg; op_b = b_re_reg; mac_ctl.tgt = cau_pkg::ACC_RE_ADD; end
            4'b1_011: begin op_a = a_im_reg; op_b = b_im_reg; mac_ctl.tgt = cau_pkg::ACC_RE_ADD; end
            4'b1_100: begin op_a = a_im_reg; op_b = b_re_reg; mac_ctl.tgt = cau_pkg::ACC_IM_ADD; end
            4'b1_101: begin op_a = a_re_reg; op_b = b_im_reg; mac_ctl.tgt = cau_pkg::ACC_IM_SUB; end
            default:  mac_ctl.tgt = cau_pkg::ACC_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= cau_pkg::ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg <= st_next;
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (rsp.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (st_reg)
            cau_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    kind_reg <= req.kind;
                    sat_reg  <= 1'b0;
                    dz_reg   <= 1'b0;
                    step_reg <= 3'd0;
                    if (req.kind == cau_pkg::KIND_POW)
                    begin
                        a_re_reg     <= cau_pkg::Q_ONE;
                        a_im_reg     <= '0;
                        b_re_reg     <= req.x_re;
                        b_im_reg     <= req.x_im;
                        div_mode_reg <= (exp_clamp < 0);
                        cnt_reg      <= (exp_clamp < 0) ? (NW-1)'(-exp_clamp)
                                                        : (NW-1)'(exp_clamp);
                    end
                    else
                    begin
                        a_re_reg     <= req.x_re;
                        a_im_reg     <= req.x_im;
                        b_re_reg     <= req.y_re;
                        b_im_reg     <= req.y_im;
                        div_mode_reg <= (req.kind == cau_pkg::KIND_DIV);
                    end
                end
            end
            cau_pkg::ST_ALU:
            begin
                case (kind_reg)
                    cau_pkg::KIND_ADD, cau_pkg::KIND_SUB:
                    begin
                        a_re_reg <= alu_re.val;
                        a_im_reg <= alu_im.val;
                        sat_reg  <= alu_re.sat | alu_im.sat;
                    end
                    cau_pkg::KIND_COPY:
                    begin
                        a_re_reg <= b_re_reg;
                        a_im_reg <= b_im_reg;
                    end
                    default:
                    begin
                        a_re_reg <= '0;
                        a_im_reg <= '0;
                    end
                endcase
            end
            cau_pkg::ST_MAC:
            begin
                step_reg <= step_reg + 3'd1;
            end
            cau_pkg::ST_MRND:
            begin
                a_re_reg <= mr_re.val;
                a_im_reg <= mr_im.val;
                sat_reg  <= sat_reg | mr_re.sat | mr_im.sat;
            end
            cau_pkg::ST_DCHK:
            begin
                nre_neg_reg <= acc_re[64];
                nim_neg_reg <= acc_im[64];
                if (acc_den == 64'd0)
                begin
                    dz_reg <= 1'b1;
                end
            end
            cau_pkg::ST_DRND:
            begin
                sat_reg <= sat_reg | dr_re.sat | dr_im.sat;
                // the reciprocal becomes the base of the power loop
                if (kind_reg == cau_pkg::KIND_POW)
                begin
                    b_re_reg <= dr_re.val;
                    b_im_reg <= dr_im.val;
                end
                else
                begin
                    a_re_reg <= dr_re.val;
                    a_im_reg <= dr_im.val;
                end
            end
            cau_pkg::ST_PLOOP:
            begin
                if (cnt_reg != '0)
                begin
                    cnt_reg      <= cnt_reg - 1'b1;
                    step_reg     <= 3'd0;
                    div_mode_reg <= 1'b0;
                end
            end
            default:
            begin
                step_reg <= step_reg;
            end
        endcase
        if (load_out)
        begin
            out_re_reg  <= dz_reg ? 32'sd0 : a_re_reg;
            out_im_reg  <= dz_reg ? 32'sd0 : a_im_reg;
            out_dz_reg  <= dz_reg;
            out_sat_reg <= sat_reg & ~dz_reg;
        end
    end

    cau_mac u_mac
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .acc_re  (acc_re),
        .acc_im  (acc_im),
        .acc_den (acc_den)
    );

    cau_div u_div
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (div_start),
        .num_re (mag_re[63:0]),
        .num_im (mag_im[63:0]),
        .den    (acc_den),
        .done   (div_done),
        .q_re   (q_re),
        .q_im   (q_im),
        .ovf_re (ovf_re),
        .ovf_im (ovf_im)
    );

    assign rsp.valid     = out_valid_reg;
    assign rsp.res_re    = out_re_reg;
    assign rsp.res_im    = out_im_reg;
    assign rsp.div_zero  = out_dz_reg;
    assign rsp.saturated = out_sat_reg;

    a_dz_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.div_zero |-> rsp.res_re == 0 && rsp.res_im == 0 && !rsp.saturated)
        else $error("division by zero beat carries data");

    a_drnd_after_wait: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == cau_pkg::ST_DRND |-> $past(st_reg) == cau_pkg::ST_DWAIT && $past(div_done))
        else $error("quotient rounded before divider finished");

    a_done_holds: assert property (@(posedge clk) disable iff (!rst_n)
        st_reg == cau_pkg::ST_DONE && out_valid_reg && !rsp.ready |=> st_reg == cau_pkg::ST_DONE)
        else $error("result dropped while output register full");

endmodule
